// ===== design/blwir_pkg.sv =====
`timescale 1ns / 1ps

package blwir_pkg;

  localparam int DATA_W = 32;
  localparam int REQ_W  = 3;
  localparam int POS_W  = 6;
  localparam int STAT_W = 2;
  localparam int CNT_OUT_W = 6;

  typedef logic signed [DATA_W-1:0] data_t;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_BACK    = 3'd0,
    REQ_PUSH_FRONT   = 3'd1,
    REQ_REMOVE_FIRST = 3'd2,
    REQ_DUMP         = 3'd3,
    REQ_INSERT       = 3'd4,
    REQ_REVERSE      = 3'd5
  } req_t;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_BADPOS = 2'd2,
    STAT_EMPTY  = 2'd3
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_DUMP = 2'd2
  } ctl_state_t;

  // Per-cycle operation broadcast to every cell
  typedef enum logic [2:0] {
    CELL_HOLD    = 3'd0,
    CELL_LOAD_AT = 3'd1,
    CELL_INSERT  = 3'd2,
    CELL_ROT_L   = 3'd3,
    CELL_ROT_R   = 3'd4
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [POS_W-1:0] sel;
  } cell_ctrl_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    data_t            item_value;
    logic [POS_W-1:0] position;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]    status;
    data_t                out_value;
    logic                 last;
    logic [CNT_OUT_W-1:0] element_count;
  } out_item_t;

endpackage

// ===== design/blwir_cell.sv =====
`timescale 1ns / 1ps

module blwir_cell import blwir_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  data_t      ins_val,
  input  data_t      left_val,
  input  data_t      right_val,
  output data_t      val
);

  localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

  data_t val_r;
  data_t val_nxt;

  // Pick the next value from self, new value or a neighbor
  always_comb begin
    val_nxt = val_r;
    case (ctrl.op)
      CELL_LOAD_AT: begin
        if (ctrl.sel == MY_IDX) val_nxt = ins_val;
      end
      CELL_INSERT: begin
        if (ctrl.sel == MY_IDX) begin
          val_nxt = ins_val;
        end else if (MY_IDX > ctrl.sel) begin
          val_nxt = left_val;
        end
      end
      CELL_ROT_L: val_nxt = right_val;
      CELL_ROT_R: val_nxt = left_val;
      default:    val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

// ===== design/bounded_list_with_insert_reverse.sv =====
`timescale 1ns / 1ps

// Channel | Ports                          | Beat
// --------+--------------------------------+-------------------------------
// request | in_valid, in_ready, in_item    | req_type, item_value, position
// result  | out_valid, out_ready, out_item | status, out_value, last, count
//
// A request beat is taken in S_IDLE and executed in S_EXEC, once the result
// register is free. Every request but a non-empty dump gives one beat. A
// non-empty dump turns the cell ring through all DEPTH cells, one step a
// cycle, but a step that emits a beat waits while the result register is
// full. Reset (rst_n, synchronous, active low) empties the list and clears
// the direction bit; cell contents are kept.

module bounded_list_with_insert_reverse import blwir_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = POS_W + 1;

  ctl_state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             rev_r, rev_nxt;
  logic [IDX_W-1:0] step_r, step_nxt;
  in_item_t         req_r, req_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  cell_ctrl_t ctrl;
  data_t      cell_val [DEPTH];

  logic             slot_free;
  logic             full;
  logic             empty;
  logic [CMP_W-1:0] count_ext;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] step_ext;
  logic             dump_emit;
  logic             dump_last;
  logic             dump_done;
  logic             dump_adv;

  // Ring of cells, each wired to its two neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam int LEFT  = (i == 0) ? DEPTH - 1 : i - 1;
    localparam int RIGHT = (i == DEPTH - 1) ? 0 : i + 1;
    blwir_cell #(.IDX(i)) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .ins_val   (req_r.item_value),
      .left_val  (cell_val[LEFT]),
      .right_val (cell_val[RIGHT]),
      .val       (cell_val[i])
    );
  end

  assign slot_free = !out_valid_r || out_ready;
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign count_ext = CMP_W'(count_r);
  assign pos_ext   = CMP_W'(req_r.position);
  assign step_ext  = CMP_W'(step_r);

  // Dump window: forward reads cell 0 on the first count steps,
  // reverse reads the top cell on the last count steps
  assign dump_emit = rev_r ? ((step_ext + count_ext) >= CMP_W'(DEPTH))
                           : (step_ext < count_ext);
  assign dump_last = rev_r ? (step_r == IDX_W'(DEPTH - 1))
                           : ((step_ext + CMP_W'(1)) == count_ext);
  assign dump_done = (step_r == IDX_W'(DEPTH - 1));
  assign dump_adv  = (state_r == S_DUMP) && (!dump_emit || slot_free);

  // Next state, cell command and result beat
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rev_nxt       = rev_r;
    step_nxt      = step_r;
    req_nxt       = req_r;
    ctrl.op       = CELL_HOLD;
    ctrl.sel      = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    in_ready      = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_item;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        if (slot_free) begin
          out_item_nxt.status    = STAT_OK;
          out_item_nxt.out_value = '0;
          out_item_nxt.last      = 1'b1;
          state_nxt              = S_IDLE;
          case (req_r.req_type)
            REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
              if (full) begin
                out_item_nxt.status = STAT_FULL;
              end else begin
                // place at the physical tail or shift in at cell 0
                if ((req_r.req_type == REQ_PUSH_BACK) != rev_r) begin
                  ctrl.op  = CELL_LOAD_AT;
                  ctrl.sel = POS_W'(count_r);
                end else begin
                  ctrl.op  = CELL_INSERT;
                  ctrl.sel = '0;
                end
                count_nxt = count_r + CNT_W'(1);
              end
            end
            REQ_REMOVE_FIRST: begin
              if (empty) begin
                out_item_nxt.status = STAT_EMPTY;
              end else begin
                if (!rev_r) ctrl.op = CELL_ROT_L;
                count_nxt = count_r - CNT_W'(1);
              end
            end
            REQ_DUMP: begin
              if (empty) begin
                out_item_nxt.status = STAT_EMPTY;
              end else begin
                state_nxt = S_DUMP;
                step_nxt  = '0;
              end
            end
            REQ_INSERT: begin
              if (pos_ext == '0 || pos_ext >= count_ext) begin
                out_item_nxt.status = STAT_BADPOS;
              end else if (full) begin
                out_item_nxt.status = STAT_FULL;
              end else begin
                ctrl.op   = CELL_INSERT;
                ctrl.sel  = rev_r ? POS_W'(count_ext - pos_ext) : req_r.position;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            REQ_REVERSE: begin
              rev_nxt = !rev_r;
            end
            default: begin
              out_item_nxt.status = STAT_OK;
            end
          endcase
          out_item_nxt.element_count = CNT_OUT_W'(count_nxt);
          if (state_nxt == S_IDLE) out_valid_nxt = 1'b1;
        end
      end

      S_DUMP: begin
        if (dump_adv) begin
          ctrl.op  = rev_r ? CELL_ROT_R : CELL_ROT_L;
          step_nxt = step_r + IDX_W'(1);
          if (dump_emit) begin
            out_valid_nxt              = 1'b1;
            out_item_nxt.status        = STAT_OK;
            out_item_nxt.out_value     = rev_r ? cell_val[DEPTH-1] : cell_val[0];
            out_item_nxt.last          = dump_last;
            out_item_nxt.element_count = CNT_OUT_W'(count_r);
          end
          if (dump_done) state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rev_r       <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rev_r       <= rev_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Fill never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("element count above capacity");

  // A taken request enters S_EXEC next
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_EXEC)
    else $error("accepted request not executed");

  // Dump leaves the count alone
  a_dump_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DUMP |=> count_r == $past(count_r))
    else $error("count changed during dump");

  // Dump ends after the final ring step
  a_dump_end: assert property (@(posedge clk) disable iff (!rst_n)
    dump_adv && dump_done |=> state_r == S_IDLE)
    else $error("dump did not end after last step");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import blwir_pkg::*;

  localparam int DEPTH          = 32;
  localparam int RANDOM_ITEMS   = 420;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 2 * DEPTH + 16;
  localparam int MAX_REPORTS    = 10;

  // Request codes the block decodes as no-ops
  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

  // Receiver stall modes
  localparam int RX_FREE   = 0;
  localparam int RX_COIN   = 1;
  localparam int RX_SPARSE = 2;
  localparam int RX_HOLD   = 3;

  // Stimulus phase biases
  localparam int PH_GROW   = 0;
  localparam int PH_SHRINK = 1;
  localparam int PH_MIXED  = 2;

  typedef struct {
    in_item_t beat;
    bit       drain_first;
  } pending_req_t;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  pending_req_t req_q[$];
  out_item_t    expected_q[$];
  data_t        list_q[$];
  int           gen_count;
  int           mismatch_count;
  int           idle_cycles;
  int           burst_left;
  int           gap_left;
  int           rx_mode;
  int           rx_left;

  bounded_list_with_insert_reverse #(.DEPTH(DEPTH)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Apply one request to the list and queue the beats it should produce
  function automatic void predict_list_beats(in_item_t b);
    out_item_t r;
    status_t   st;
    data_t     flipped[$];
    int        n;
    st = STAT_OK;
    n  = list_q.size();
    r  = '0;
    case (b.req_type)
      REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
        if (n >= DEPTH) st = STAT_FULL;
        else if (b.req_type == REQ_PUSH_BACK) list_q = {list_q, b.item_value};
        else list_q = {b.item_value, list_q};
      end
      REQ_REMOVE_FIRST: begin
        if (n == 0) st = STAT_EMPTY;
        else void'(list_q.pop_front());
      end
      REQ_DUMP: begin
        if (n == 0) begin
          st = STAT_EMPTY;
        end else begin
          for (int i = 0; i < n; i++) begin
            r.status        = STAT_OK;
            r.out_value     = list_q[i];
            r.last          = (i == n - 1);
            r.element_count = n[CNT_OUT_W-1:0];
            expected_q      = {expected_q, r};
          end
          return;
        end
      end
      REQ_INSERT: begin
        if (b.position < 1 || int'(b.position) >= n) st = STAT_BADPOS;
        else if (n >= DEPTH) st = STAT_FULL;
        else list_q.insert(int'(b.position), b.item_value);
      end
      REQ_REVERSE: begin
        foreach (list_q[i]) flipped = {list_q[i], flipped};
        list_q = flipped;
      end
      default: ;
    endcase
    r.status        = st;
    r.out_value     = '0;
    r.last          = 1'b1;
    r.element_count = CNT_OUT_W'(list_q.size());
    expected_q      = {expected_q, r};
  endfunction

  // Queue a request and track the element count it leaves behind
  task automatic queue_request(logic [REQ_W-1:0] code, data_t v, logic [POS_W-1:0] p,
                               bit drain);
    pending_req_t pr;
    pr.beat.req_type   = code;
    pr.beat.item_value = v;
    pr.beat.position   = p;
    pr.drain_first     = drain;
    req_q = {req_q, pr};
    case (code)
      REQ_PUSH_BACK, REQ_PUSH_FRONT: if (gen_count < DEPTH) gen_count++;
      REQ_REMOVE_FIRST: if (gen_count > 0) gen_count--;
      REQ_INSERT: if (p >= 1 && int'(p) < gen_count && gen_count < DEPTH) gen_count++;
      default: ;
    endcase
  endtask

  // Stimulus, reset and end of run
  initial begin
    int                total;
    int                bias;
    int                phase_len;
    int                roll;
    int                w_pb, w_pf, w_rm, w_ins, w_dump, w_rev;
    logic [REQ_W-1:0]  code;
    logic [POS_W-1:0]  pos;
    bit                first_random;

    gen_count      = 0;
    mismatch_count = 0;

    // Directed: empty-list cases, value extremes, insert bounds, reverse, spare codes
    queue_request(REQ_DUMP,         32'sd0,          6'd0,  1'b0);
    queue_request(REQ_REMOVE_FIRST, 32'sd0,          6'd0,  1'b0);
    queue_request(REQ_INSERT,       32'sd7,          6'd0,  1'b0);
    queue_request(REQ_PUSH_BACK,    32'h7fff_ffff,   6'd0,  1'b0);
    queue_request(REQ_PUSH_FRONT,   32'h8000_0000,   6'd0,  1'b0);
    queue_request(REQ_PUSH_BACK,    32'sd0,          6'd63, 1'b0);
    queue_request(REQ_PUSH_BACK,    -32'sd1,         6'd0,  1'b0);
    queue_request(REQ_INSERT,       32'h5555_5555,   6'd1,  1'b0);
    queue_request(REQ_INSERT,       32'haaaa_aaaa,   6'd4,  1'b0);
    queue_request(REQ_INSERT,       32'sd99,         6'd6,  1'b0);
    queue_request(REQ_INSERT,       32'sd98,         6'd63, 1'b0);
    queue_request(REQ_DUMP,         32'sd0,          6'd0,  1'b0);
    queue_request(REQ_REVERSE,      32'sd0,          6'd0,  1'b0);
    queue_request(REQ_PUSH_BACK,    32'sd123,        6'd0,  1'b0);
    queue_request(REQ_PUSH_FRONT,   -32'sd5,         6'd0,  1'b0);
    queue_request(REQ_DUMP,         32'sd0,          6'd0,  1'b0);
    queue_request(REQ_REMOVE_FIRST, 32'sd0,          6'd0,  1'b0);
    queue_request(REQ_DUMP,         32'sd0,          6'd0,  1'b0);
    queue_request(REQ_REVERSE,      32'sd0,          6'd0,  1'b0);
    queue_request(REQ_INSERT,       32'sd4242,       6'd2,  1'b0);
    queue_request(REQ_DUMP,         32'sd0,          6'd0,  1'b0);
    queue_request(REQ_SPARE_LO,     $urandom,        6'd21, 1'b0);
    queue_request(REQ_SPARE_HI,     $urandom,        6'd42, 1'b0);
    queue_request(REQ_REMOVE_FIRST, 32'sd0,          6'd0,  1'b0);

    // Random: phases that grow, shrink or churn the list
    total        = 0;
    first_random = 1'b1;
    while (total < RANDOM_ITEMS) begin
      bias      = $urandom_range(PH_MIXED, PH_GROW);
      phase_len = $urandom_range(45, 15);
      case (bias)
        PH_GROW:   begin w_pb = 35; w_pf = 30; w_rm = 5;  w_ins = 15; w_dump = 7;  w_rev = 6;  end
        PH_SHRINK: begin w_pb = 10; w_pf = 8;  w_rm = 50; w_ins = 10; w_dump = 12; w_rev = 8;  end
        default:   begin w_pb = 18; w_pf = 17; w_rm = 20; w_ins = 20; w_dump = 12; w_rev = 11; end
      endcase
      for (int k = 0; k < phase_len; k++) begin
        roll = $urandom_range(99, 0);
        if (roll < w_pb) code = REQ_PUSH_BACK;
        else if (roll < w_pb + w_pf) code = REQ_PUSH_FRONT;
        else if (roll < w_pb + w_pf + w_rm) code = REQ_REMOVE_FIRST;
        else if (roll < w_pb + w_pf + w_rm + w_ins) code = REQ_INSERT;
        else if (roll < w_pb + w_pf + w_rm + w_ins + w_dump) code = REQ_DUMP;
        else if (roll < w_pb + w_pf + w_rm + w_ins + w_dump + w_rev) code = REQ_REVERSE;
        else code = ($urandom_range(1, 0) == 0) ? REQ_SPARE_LO : REQ_SPARE_HI;
        if (code == REQ_INSERT && gen_count >= 2 && $urandom_range(99, 0) < 75)
          pos = POS_W'($urandom_range(gen_count - 1, 1));
        else
          pos = POS_W'($urandom_range(63, 0));
        queue_request(code, $urandom, pos,
                      first_random || (k == 0 && $urandom_range(2, 0) == 0));
        first_random = 1'b0;
        if (code != REQ_SPARE_LO && code != REQ_SPARE_HI) total++;
      end
    end

    // Hold reset, then release
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for all requests to go out and all beats to come back
    while (req_q.size() != 0 || in_valid || expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Driver: bursts of requests with random gaps; drain before flagged requests
  always @(posedge clk) begin
    pending_req_t nxt;
    bit           take;
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      take = in_valid && in_ready;
      if (take) predict_list_beats(in_item);
      if (!in_valid || take) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_q.size() != 0 &&
                     !(req_q[0].drain_first && expected_q.size() != 0)) begin
          nxt = req_q.pop_front();
          in_valid <= 1'b1;
          in_item  <= nxt.beat;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(24, 1);
            gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: segments of free flow, coin flips, sparse accepts and long holds
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_mode   = RX_FREE;
      rx_left   = 0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(RX_HOLD, RX_FREE);
        rx_left = $urandom_range(60, 8);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_FREE:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= $urandom_range(1, 0);
        RX_SPARSE: out_ready <= ($urandom_range(3, 0) == 0);
        default:   out_ready <= (rx_left < 5);
      endcase
    end
  end

  // Monitor: check each result beat against the oldest expectation
  always @(posedge clk) begin
    out_item_t exp_beat;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result beat: status=%0d value=%0d last=%0d count=%0d",
                   out_item.status, out_item.out_value, out_item.last,
                   out_item.element_count);
      end else begin
        exp_beat = expected_q.pop_front();
        if (out_item.status !== exp_beat.status ||
            out_item.out_value !== exp_beat.out_value ||
            out_item.last !== exp_beat.last ||
            out_item.element_count !== exp_beat.element_count) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("result mismatch: expected status=%0d value=%0d last=%0d count=%0d,",
                     exp_beat.status, exp_beat.out_value, exp_beat.last,
                     exp_beat.element_count,
                     " got status=%0d value=%0d last=%0d count=%0d",
                     out_item.status, out_item.out_value,
                     out_item.last, out_item.element_count);
        end
      end
    end
  end

  // Watchdog: end the run if no beat moves for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== sim.f =====
design/blwir_pkg.sv
design/blwir_cell.sv
design/bounded_list_with_insert_reverse.sv
test/tb.sv
